// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define TDB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define TDB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/tdb_pkg.sv =====
// ----------------------------------------------------------------------------
// tdb_pkg
// Types, register indexes and arithmetic helpers of the blend pixel unit.
// ----------------------------------------------------------------------------
package tdb_pkg;

    typedef enum logic [2:0] {
        REG_TINT_ARGB         = 3'd0,
        REG_DITHER_ENABLE     = 3'd1,
        REG_DITHER_INTENSITY  = 3'd2,
        REG_DITHER_JITTER     = 3'd3,
        REG_DEPTH_TEST_ENABLE = 3'd4,
        REG_DRAW_DEPTH        = 3'd5
    } cfg_reg_e;

    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS  = 32;
    localparam int unsigned FIELD_DEPTH_BITS = 16;

    typedef struct packed {
        logic [31:0] tint_argb;
        logic        dither_enable;
        logic [7:0]  dither_intensity;
        logic [1:0]  dither_jitter;
        logic        depth_test_enable;
        logic [15:0] draw_depth;
    } cfg_t;

    typedef struct packed {
        logic [31:0] src_texel;
        logic [23:0] dst_pixel;
        logic [15:0] stored_depth;
        logic [1:0]  pixel_x_low;
        logic [1:0]  pixel_y_low;
    } frag_t;

    // Tinted fragment as it moves through dither and blend.
    typedef struct packed {
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [23:0] dst;
        logic [3:0]  bidx;
        logic        live;
    } pix_t;

    typedef struct packed {
        logic        pixel_write;
        logic [23:0] pixel_out;
        logic        depth_write;
    } result_t;

    // floor(y / 255), exact for y below 65535.
    function automatic logic [8:0] div255_floor(input logic [16:0] y);
        logic [16:0] s;
        s = y + {8'd0, y[16:8]} + 17'd1;
        return s[16:8];
    endfunction

    // (x + 127) / 255 for x up to 255 * 255.
    function automatic logic [7:0] div255_round(input logic [15:0] x);
        logic [8:0] q;
        q = div255_floor({1'b0, x} + 17'd127);
        return q[7:0];
    endfunction

    function automatic logic [7:0] bayer_lut(input logic [3:0] idx);
        logic [7:0] v;
        unique case (idx)
            4'd0:  v = 8'd8;
            4'd1:  v = 8'd135;
            4'd2:  v = 8'd39;
            4'd3:  v = 8'd167;
            4'd4:  v = 8'd199;
            4'd5:  v = 8'd71;
            4'd6:  v = 8'd231;
            4'd7:  v = 8'd103;
            4'd8:  v = 8'd55;
            4'd9:  v = 8'd183;
            4'd10: v = 8'd23;
            4'd11: v = 8'd151;
            4'd12: v = 8'd247;
            4'd13: v = 8'd119;
            4'd14: v = 8'd215;
            4'd15: v = 8'd87;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // Smoothstep guard over luminance: zero in the dark end, full above the ramp.
    function automatic logic [7:0] guard_lut(input logic [7:0] lum);
        logic [7:0] off;
        logic [7:0] v;
        off = lum - 8'd9;
        if (lum < 8'd9) begin
            v = 8'd0;
        end else if (lum > 8'd24) begin
            v = 8'd255;
        end else begin
            unique case (off[3:0])
                4'd0:  v = 8'd2;
                4'd1:  v = 8'd8;
                4'd2:  v = 8'd19;
                4'd3:  v = 8'd34;
                4'd4:  v = 8'd52;
                4'd5:  v = 8'd72;
                4'd6:  v = 8'd94;
                4'd7:  v = 8'd117;
                4'd8:  v = 8'd140;
                4'd9:  v = 8'd163;
                4'd10: v = 8'd185;
                4'd11: v = 8'd205;
                4'd12: v = 8'd222;
                4'd13: v = 8'd237;
                4'd14: v = 8'd248;
                4'd15: v = 8'd254;
                default: v = 8'd0;
            endcase
        end
        return v;
    endfunction

endpackage

// ===== rtl/tdb_tint.sv =====
// ----------------------------------------------------------------------------
// tdb_tint
// Two pipeline stages: tint products and depth/alpha checks, then rounding.
// ----------------------------------------------------------------------------
module tdb_tint #(
    parameter int unsigned DEPTH_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tdb_pkg::frag_t in_frag,
    input  tdb_pkg::cfg_t  cfg,
    output logic           out_valid,
    input  logic           out_ready,
    output tdb_pkg::pix_t  out_pix
);

    localparam int unsigned CmpBits =
        (DEPTH_BITS < tdb_pkg::FIELD_DEPTH_BITS) ? DEPTH_BITS : tdb_pkg::FIELD_DEPTH_BITS;

    typedef struct packed {
        logic [15:0] pr;
        logic [15:0] pg;
        logic [15:0] pb;
        logic [15:0] pa;
        logic [23:0] dst;
        logic [3:0]  bidx;
        logic        live;
    } prod_t;

    logic          valid0_reg, valid1_reg;
    logic          en0, en1;
    prod_t         prod_reg, prod_next;
    tdb_pkg::pix_t pix_reg, pix_next;
    logic [1:0]    x_j, y_j;
    logic          depth_fail;

    assign en1      = !valid1_reg || out_ready;
    assign en0      = !valid0_reg || en1;
    assign in_ready = en0;

    assign x_j = in_frag.pixel_x_low + cfg.dither_jitter;
    assign y_j = in_frag.pixel_y_low + cfg.dither_jitter;
    assign depth_fail = cfg.depth_test_enable &&
        (cfg.draw_depth[CmpBits-1:0] > in_frag.stored_depth[CmpBits-1:0]);

    always_comb begin
        prod_next.pr   = {8'd0, in_frag.src_texel[23:16]} * {8'd0, cfg.tint_argb[23:16]};
        prod_next.pg   = {8'd0, in_frag.src_texel[15:8]}  * {8'd0, cfg.tint_argb[15:8]};
        prod_next.pb   = {8'd0, in_frag.src_texel[7:0]}   * {8'd0, cfg.tint_argb[7:0]};
        prod_next.pa   = {8'd0, in_frag.src_texel[31:24]} * {8'd0, cfg.tint_argb[31:24]};
        prod_next.dst  = in_frag.dst_pixel;
        prod_next.bidx = {y_j, x_j};
        prod_next.live = !depth_fail && (in_frag.src_texel[31:24] != 8'd0);
    end

    always_comb begin
        pix_next.r    = tdb_pkg::div255_round(prod_reg.pr);
        pix_next.g    = tdb_pkg::div255_round(prod_reg.pg);
        pix_next.b    = tdb_pkg::div255_round(prod_reg.pb);
        pix_next.a    = tdb_pkg::div255_round(prod_reg.pa);
        pix_next.dst  = prod_reg.dst;
        pix_next.bidx = prod_reg.bidx;
        // A tint that rounds alpha to zero drops the pixel as well.
        pix_next.live = prod_reg.live && (pix_next.a != 8'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
        end else begin
            if (en0) valid0_reg <= in_valid;
            if (en1) valid1_reg <= valid0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en0) prod_reg <= prod_next;
        if (en1) pix_reg  <= pix_next;
    end

    assign out_valid = valid1_reg;
    assign out_pix   = pix_reg;

endmodule

// ===== rtl/tdb_dither.sv =====
// ----------------------------------------------------------------------------
// tdb_dither
// Seven-stage ordered dither: luminance, guard scaling, Bayer threshold and
// five-bit requantization of each channel when dither_on is set.
// ----------------------------------------------------------------------------
module tdb_dither (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  tdb_pkg::pix_t in_pix,
    input  tdb_pkg::cfg_t cfg,
    output logic          out_valid,
    input  logic          out_ready,
    output tdb_pkg::pix_t out_pix
);

    localparam int unsigned Stages = 7;

    typedef struct packed {
        tdb_pkg::pix_t pix;
        logic [15:0]   work;
        logic [12:0]   sr;
        logic [12:0]   sg;
        logic [12:0]   sb;
    } ds_t;

    logic [Stages-1:0] valid_reg;
    logic [Stages-1:0] en;
    ds_t               d_reg  [Stages];
    ds_t               d_next [Stages];
    logic              dither_on;

    function automatic logic [12:0] scaled_sum(input logic [7:0] c, input logic [7:0] thr);
        return {5'd0, c} * 13'd31 + {5'd0, thr};
    endfunction

    // Five-bit level, clamped, widened back to eight bits by bit replication.
    function automatic logic [7:0] requant(input logic [12:0] s);
        logic [8:0] q;
        logic [4:0] q5;
        q  = tdb_pkg::div255_floor({4'd0, s});
        q5 = (q > 9'd31) ? 5'd31 : q[4:0];
        return {q5, q5[4:2]};
    endfunction

    assign dither_on = cfg.dither_enable && (cfg.dither_intensity != 8'd0);

    always_comb begin
        for (int i = Stages - 1; i >= 0; i--) begin
            if (i == Stages - 1) begin
                en[i] = !valid_reg[i] || out_ready;
            end else begin
                en[i] = !valid_reg[i] || en[i+1];
            end
        end
    end
    assign in_ready = en[0];

    always_comb begin
        logic [15:0] lum_sum;
        lum_sum = {8'd0, in_pix.r} * 16'd77 + {8'd0, in_pix.g} * 16'd150
                + {8'd0, in_pix.b} * 16'd29;
        d_next[0]      = d_reg[0];
        d_next[0].pix  = in_pix;
        d_next[0].work = {8'd0, lum_sum[15:8]};
        d_next[0].sr   = '0;
        d_next[0].sg   = '0;
        d_next[0].sb   = '0;

        d_next[1]      = d_reg[0];
        d_next[1].work = {8'd0, tdb_pkg::guard_lut(d_reg[0].work[7:0])}
                       * {8'd0, cfg.dither_intensity};

        d_next[2]      = d_reg[1];
        d_next[2].work = {8'd0, tdb_pkg::div255_round(d_reg[1].work)};

        d_next[3]      = d_reg[2];
        d_next[3].work = {8'd0, tdb_pkg::bayer_lut(d_reg[2].pix.bidx)}
                       * {8'd0, d_reg[2].work[7:0]};

        d_next[4]      = d_reg[3];
        d_next[4].work = {8'd0, tdb_pkg::div255_round(d_reg[3].work)};

        d_next[5]    = d_reg[4];
        d_next[5].sr = scaled_sum(d_reg[4].pix.r, d_reg[4].work[7:0]);
        d_next[5].sg = scaled_sum(d_reg[4].pix.g, d_reg[4].work[7:0]);
        d_next[5].sb = scaled_sum(d_reg[4].pix.b, d_reg[4].work[7:0]);

        d_next[6] = d_reg[5];
        if (dither_on) begin
            d_next[6].pix.r = requant(d_reg[5].sr);
            d_next[6].pix.g = requant(d_reg[5].sg);
            d_next[6].pix.b = requant(d_reg[5].sb);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) valid_reg[0] <= in_valid;
            for (int i = 1; i < Stages; i++) begin
                if (en[i]) valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < Stages; i++) begin
            if (en[i]) d_reg[i] <= d_next[i];
        end
    end

    assign out_valid = valid_reg[Stages-1];
    assign out_pix   = d_reg[Stages-1].pix;

endmodule

// ===== rtl/tdb_blend.sv =====
// ----------------------------------------------------------------------------
// tdb_blend
// Alpha blend over the destination in two stages; the second stage is the
// result register of the unit.
// ----------------------------------------------------------------------------
module tdb_blend (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  tdb_pkg::pix_t    in_pix,
    input  tdb_pkg::cfg_t    cfg,
    output logic             out_valid,
    input  logic             out_ready,
    output tdb_pkg::result_t out_result
);

    typedef struct packed {
        logic [15:0] sr;
        logic [15:0] sg;
        logic [15:0] sb;
        logic        live;
    } bs_t;

    logic             valid0_reg, valid1_reg;
    logic             en0, en1;
    bs_t              sum_reg, sum_next;
    tdb_pkg::result_t res_reg, res_next;
    logic [7:0]       ia;

    assign en1      = !valid1_reg || out_ready;
    assign en0      = !valid0_reg || en1;
    assign in_ready = en0;

    // With full alpha the weighted sum is c * 255, which rounds back to c.
    assign ia = 8'd255 - in_pix.a;

    always_comb begin
        sum_next.sr   = {8'd0, in_pix.r} * {8'd0, in_pix.a}
                      + {8'd0, in_pix.dst[23:16]} * {8'd0, ia};
        sum_next.sg   = {8'd0, in_pix.g} * {8'd0, in_pix.a}
                      + {8'd0, in_pix.dst[15:8]} * {8'd0, ia};
        sum_next.sb   = {8'd0, in_pix.b} * {8'd0, in_pix.a}
                      + {8'd0, in_pix.dst[7:0]} * {8'd0, ia};
        sum_next.live = in_pix.live;
    end

    always_comb begin
        res_next.pixel_write = sum_reg.live;
        res_next.depth_write = sum_reg.live && cfg.depth_test_enable;
        if (sum_reg.live) begin
            res_next.pixel_out = {tdb_pkg::div255_round(sum_reg.sr),
                                  tdb_pkg::div255_round(sum_reg.sg),
                                  tdb_pkg::div255_round(sum_reg.sb)};
        end else begin
            res_next.pixel_out = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
        end else begin
            if (en0) valid0_reg <= in_valid;
            if (en1) valid1_reg <= valid0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en0) sum_reg <= sum_next;
        if (en1) res_reg <= res_next;
    end

    assign out_valid  = valid1_reg;
    assign out_result = res_reg;

endmodule

// ===== rtl/tinted_dithered_blend_pixel_unit.sv =====
// Tinted, dithered alpha-blend fragment unit. It takes one fragment request per
// clock while the result side is not stalled, and returns exactly one result per
// request, in order, after two stages of tinting, seven of ordered dither and two
// of blending, each holding one request. The pipeline stages have their own valid
// bits and stall independently, so bubbles are squeezed out and new requests keep
// entering while a finished result waits on m_tready, until every stage is full.
// Configuration is written through cfg_we/cfg_index/cfg_wdata and must only
// change while no request is in flight.
// ----------------------------------------------------------------------------
// tinted_dithered_blend_pixel_unit
// Top level: configuration registers, stream ports and pipeline chain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tinted_dithered_blend_pixel_unit #(
    parameter int unsigned DEPTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // src_texel[31:0], dst_pixel[55:32], stored_depth[71:56],
    // pixel_x_low[73:72], pixel_y_low[75:74], zero fill [79:76]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_write[0], pixel_out[24:1], depth_write[25], zero fill [31:26]
    output logic [31:0] m_tdata,
    input  logic                               cfg_we,
    input  logic [tdb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tdb_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    logic [31:0] tint_argb_reg;
    logic        dither_enable_reg;
    logic [7:0]  dither_intensity_reg;
    logic [1:0]  dither_jitter_reg;
    logic        depth_test_enable_reg;
    logic [15:0] draw_depth_reg;

    tdb_pkg::cfg_t    cfg;
    tdb_pkg::frag_t   frag;
    tdb_pkg::pix_t    tint_pix, dith_pix;
    tdb_pkg::result_t result;
    logic             tint_valid, tint_ready, dith_valid, dith_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tint_argb_reg         <= 32'hFFFF_FFFF;
            dither_enable_reg     <= 1'b0;
            dither_intensity_reg  <= 8'd0;
            dither_jitter_reg     <= 2'd0;
            depth_test_enable_reg <= 1'b0;
            draw_depth_reg        <= 16'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tdb_pkg::REG_TINT_ARGB:         tint_argb_reg <= cfg_wdata[31:0];
                tdb_pkg::REG_DITHER_ENABLE:     dither_enable_reg <= cfg_wdata[0];
                tdb_pkg::REG_DITHER_INTENSITY:  dither_intensity_reg <= cfg_wdata[7:0];
                tdb_pkg::REG_DITHER_JITTER:     dither_jitter_reg <= cfg_wdata[1:0];
                tdb_pkg::REG_DEPTH_TEST_ENABLE: depth_test_enable_reg <= cfg_wdata[0];
                tdb_pkg::REG_DRAW_DEPTH:        draw_depth_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.tint_argb         = tint_argb_reg;
        cfg.dither_enable     = dither_enable_reg;
        cfg.dither_intensity  = dither_intensity_reg;
        cfg.dither_jitter     = dither_jitter_reg;
        cfg.depth_test_enable = depth_test_enable_reg;
        cfg.draw_depth        = draw_depth_reg;
    end

    always_comb begin
        frag.src_texel    = s_tdata[31:0];
        frag.dst_pixel    = s_tdata[55:32];
        frag.stored_depth = s_tdata[71:56];
        frag.pixel_x_low  = s_tdata[73:72];
        frag.pixel_y_low  = s_tdata[75:74];
    end

    tdb_tint #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_tint (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_frag  (frag),
        .cfg      (cfg),
        .out_valid(tint_valid),
        .out_ready(tint_ready),
        .out_pix  (tint_pix)
    );

    tdb_dither u_dither (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (tint_valid),
        .in_ready (tint_ready),
        .in_pix   (tint_pix),
        .cfg      (cfg),
        .out_valid(dith_valid),
        .out_ready(dith_ready),
        .out_pix  (dith_pix)
    );

    tdb_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dith_valid),
        .in_ready  (dith_ready),
        .in_pix    (dith_pix),
        .cfg       (cfg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_result(result)
    );

    assign m_tdata = {6'd0, result.depth_write, result.pixel_out, result.pixel_write};

    `TDB_ASSERT(a_no_write_zero, m_tvalid && !m_tdata[0] |-> m_tdata[24:1] == 24'd0,
                "dropped pixel carries color")
    `TDB_ASSERT(a_depth_write,
                m_tvalid && m_tdata[25] |-> m_tdata[0] && depth_test_enable_reg,
                "depth write without pixel write or depth test")
    `TDB_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready,
                "input stalled with empty result register")
    `TDB_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule
